FILE: rtl/svx_pkg.sv
// shared types and constants for the execute unit
package svx_pkg;

  localparam int NumRegs  = 8;
  localparam int RegIdxW  = 3;
  localparam int MemBytes = 65536;
  localparam int MemAddrW = 16;
  localparam int QDepth   = 2;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_HLT = 5'd1, OP_MOV_IR = 5'd2, OP_PRINT = 5'd3,
    OP_INC = 5'd4, OP_DEC = 5'd5, OP_JMP = 5'd6, OP_CMP_I = 5'd7,
    OP_JE = 5'd8, OP_JNE = 5'd9, OP_JL = 5'd10, OP_JG = 5'd11,
    OP_JLE = 5'd12, OP_JGE = 5'd13, OP_JZ = 5'd14, OP_JNZ = 5'd15,
    OP_ADD_IR = 5'd16, OP_SUB_IR = 5'd17, OP_MUL_IR = 5'd18, OP_DIV_IR = 5'd19,
    OP_MOV_RR = 5'd20, OP_MOV_MR = 5'd21, OP_MOV_IM = 5'd22, OP_MOV_RM = 5'd23,
    OP_STDIN = 5'd24, OP_ADD_RR = 5'd25, OP_IOCFG = 5'd26
  } op_e;

  // instruction word as classified by the front part
  typedef struct packed {
    logic [4:0]         op;
    logic [RegIdxW-1:0] reg_a;
    logic [RegIdxW-1:0] reg_b;
    logic [15:0]        imm;
    logic [15:0]        tgt;
    logic               key;
    logic [7:0]         kb;
    logic [2:0]         adv;
    logic               is_div;
  } instr_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD1, ST_RD2, ST_RD3, ST_WR2, ST_DIV, ST_OUT
  } bst_e;

  // program counter advance for one op
  function automatic logic [2:0] pc_adv(logic [4:0] op);
    logic [2:0] a;
    a = 3'd1;
    case (op)
      OP_HLT: a = 3'd0;
      OP_MOV_IR, OP_ADD_IR, OP_SUB_IR, OP_MUL_IR, OP_DIV_IR,
      OP_MOV_MR, OP_MOV_RM: a = 3'd4;
      OP_INC, OP_DEC, OP_STDIN: a = 3'd2;
      OP_CMP_I, OP_JE, OP_JNE, OP_JL, OP_JG, OP_JLE, OP_JGE, OP_JZ, OP_JNZ,
      OP_MOV_RR, OP_ADD_RR: a = 3'd3;
      OP_MOV_IM: a = 3'd5;
      default: a = 3'd1;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/svx_ram.sv
// generic single port ram with registered read
module svx_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // registered read, old data returned on a write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/svx_front.sv
// front part: accepts words, classifies them, queues them for the back
module svx_front import svx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         op_i,
  input  logic [2:0]         reg_a_i,
  input  logic [2:0]         reg_b_i,
  input  logic [15:0]        immediate_i,
  input  logic [15:0]        target_address_i,
  input  logic               key_present_i,
  input  logic [7:0]         key_byte_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output instr_t             q_data_o
);
  instr_t     slot_q [QDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  instr_t     cls;
  logic       push, pop;

  // classify incoming word
  always_comb begin
    cls.op     = op_i;
    cls.reg_a  = reg_a_i;
    cls.reg_b  = reg_b_i;
    cls.imm    = immediate_i;
    cls.tgt    = target_address_i;
    cls.key    = key_present_i;
    cls.kb     = key_byte_i;
    cls.adv    = pc_adv(op_i);
    cls.is_div = (op_i == OP_DIV_IR);
  end

  assign in_ready_o = (cnt_q != 2'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_data_o   = slot_q[rptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'(QDepth) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue count out of range");
`endif
endmodule

FILE: rtl/svx_back.sv
// back part: executes words against registers, flags and data memory
module svx_back import svx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  instr_t      q_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] program_counter_o,
  output logic        halted_o,
  output logic        print_valid_o,
  output logic [7:0]  print_char_o,
  output logic        flag_greater_o,
  output logic        flag_less_o,
  output logic        flag_equal_o,
  output logic        flag_zero_o,
  output logic        divide_by_zero_o
);
  bst_e st_q, st_d;
  instr_t ins_q;
  logic [15:0] regs_q [NumRegs];
  logic [15:0] pc_q;
  logic hlt_q, gt_q, lt_q, eq_q, zf_q;
  logic pv_q, dz_q;
  logic [7:0] pch_q, hi_q;
  logic [MemAddrW-1:0] clr_q;
  logic [15:0] quo_q, rem_q;
  logic [4:0]  dcnt_q;

  logic                we;
  logic [MemAddrW-1:0] addr;
  logic [7:0]          wdata, rdata;

  svx_ram #(.Width(8), .Depth(MemBytes)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic [15:0] av, bv, r0v;
  logic        jump;
  logic [16:0] rtrial;
  assign av  = regs_q[ins_q.reg_a];
  assign bv  = regs_q[ins_q.reg_b];
  assign r0v = regs_q[0];
  assign rtrial = {rem_q, quo_q[15]} - {1'b0, ins_q.imm};

  // jump condition
  always_comb begin
    case (ins_q.op)
      OP_JMP: jump = 1'b1;
      OP_JE:  jump = eq_q;
      OP_JNE: jump = !eq_q;
      OP_JL:  jump = lt_q;
      OP_JG:  jump = gt_q;
      OP_JLE: jump = lt_q || eq_q;
      OP_JGE: jump = gt_q || eq_q;
      OP_JZ:  jump = zf_q;
      OP_JNZ: jump = !zf_q;
      default: jump = 1'b0;
    endcase
  end

  // memory port control and next state
  always_comb begin
    st_d  = st_q;
    we    = 1'b0;
    addr  = ins_q.tgt;
    wdata = 8'd0;
    q_ready_o = (st_q == ST_IDLE);
    case (st_q)
      ST_CLEAR: begin
        we = 1'b1; addr = clr_q;
        if (clr_q == MemAddrW'(MemBytes - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: if (q_valid_i) st_d = ST_RD1;
      ST_RD1: begin
        if (hlt_q) st_d = ST_OUT;
        else begin
          case (ins_q.op)
            OP_PRINT: begin addr = r0v; st_d = ST_RD2; end
            OP_MOV_MR: begin addr = ins_q.tgt; st_d = ST_RD2; end
            OP_MOV_IM: begin we = 1'b1; wdata = ins_q.imm[15:8]; st_d = ST_WR2; end
            OP_MOV_RM: begin we = 1'b1; wdata = av[15:8]; st_d = ST_WR2; end
            OP_DIV_IR: st_d = (ins_q.imm == 16'd0) ? ST_OUT : ST_DIV;
            default: st_d = ST_OUT;
          endcase
        end
      end
      ST_RD2: begin
        if (ins_q.op == OP_MOV_MR) begin
          addr = ins_q.tgt + 16'd1; st_d = ST_RD3;
        end else st_d = ST_OUT;
      end
      ST_RD3: st_d = ST_OUT;
      ST_WR2: begin
        we = 1'b1; addr = ins_q.tgt + 16'd1;
        wdata = (ins_q.op == OP_MOV_IM) ? ins_q.imm[7:0] : av[7:0];
        st_d = ST_OUT;
      end
      ST_DIV: if (dcnt_q == 5'd16) st_d = ST_OUT;
      ST_OUT: if (out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_CLEAR;
    else         st_q <= st_d;
  end

  // word capture and divide datapath
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && q_valid_i) ins_q <= q_data_i;
    if (st_q == ST_RD1) begin
      quo_q <= av; rem_q <= 16'd0; dcnt_q <= 5'd0;
    end
    if (st_q == ST_DIV && dcnt_q != 5'd16) begin
      dcnt_q <= dcnt_q + 5'd1;
      if (!rtrial[16]) begin
        rem_q <= rtrial[15:0]; quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= {rem_q[14:0], quo_q[15]}; quo_q <= {quo_q[14:0], 1'b0};
      end
    end
    if (st_q == ST_RD3) hi_q <= rdata;
    if (st_q == ST_RD2 && ins_q.op == OP_MOV_MR) hi_q <= rdata;
  end

  // architectural state update at the end of a word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= 16'd0;
      pc_q <= 16'd0; hlt_q <= 1'b0; gt_q <= 1'b0; lt_q <= 1'b0;
      eq_q <= 1'b0; zf_q <= 1'b0; pv_q <= 1'b0; dz_q <= 1'b0;
      pch_q <= 8'd0; clr_q <= '0;
    end else begin
      if (st_q == ST_CLEAR) clr_q <= clr_q + MemAddrW'(1);
      if (st_q == ST_RD1) begin pv_q <= 1'b0; dz_q <= 1'b0; pch_q <= 8'd0; end
      if (st_q == ST_RD2 && ins_q.op == OP_PRINT) begin
        pv_q <= 1'b1; pch_q <= rdata;
      end
      // commit happens on the move into the output state
      if (st_d == ST_OUT && st_q != ST_OUT && !hlt_q) begin
        pc_q <= jump ? ins_q.tgt : pc_q + 16'(ins_q.adv);
        case (ins_q.op)
          OP_HLT: hlt_q <= 1'b1;
          OP_MOV_IR: regs_q[ins_q.reg_a] <= ins_q.imm;
          OP_INC: regs_q[ins_q.reg_a] <= av + 16'd1;
          OP_DEC: regs_q[ins_q.reg_a] <= av - 16'd1;
          OP_CMP_I: begin
            gt_q <= r0v > ins_q.imm; lt_q <= r0v < ins_q.imm;
            eq_q <= r0v == ins_q.imm; zf_q <= r0v == 16'd0;
          end
          OP_ADD_IR: regs_q[0] <= av + ins_q.imm;
          OP_SUB_IR: regs_q[0] <= av - ins_q.imm;
          OP_MUL_IR: regs_q[0] <= av * ins_q.imm;
          OP_DIV_IR: begin
            if (ins_q.imm == 16'd0) begin regs_q[0] <= 16'hFFFF; dz_q <= 1'b1; end
            else regs_q[0] <= quo_q;
          end
          OP_MOV_RR: regs_q[ins_q.reg_a] <= bv;
          OP_MOV_MR: regs_q[ins_q.reg_a] <= {hi_q, rdata};
          OP_STDIN: begin
            if (ins_q.key) begin
              regs_q[ins_q.reg_a] <= {8'd0, ins_q.kb}; zf_q <= 1'b0;
            end else zf_q <= 1'b1;
          end
          OP_ADD_RR: regs_q[ins_q.reg_a] <= av + bv;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o       = (st_q == ST_OUT);
  assign program_counter_o = pc_q;
  assign halted_o          = hlt_q;
  assign print_valid_o     = pv_q;
  assign print_char_o      = pch_q;
  assign flag_greater_o    = gt_q;
  assign flag_less_o       = lt_q;
  assign flag_equal_o      = eq_q;
  assign flag_zero_o       = zf_q;
  assign divide_by_zero_o  = dz_q;

`ifndef SYNTH
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_IDLE |-> !q_ready_o) else $error("queue popped while busy");
  a_print_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && print_valid_o |-> ins_q.op == OP_PRINT) else $error("stray print");
  a_dz_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> ins_q.is_div && ins_q.imm == 16'd0)
    else $error("stray divide by zero");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(hlt_q) |-> hlt_q) else $error("halt cleared");
`endif
endmodule

FILE: rtl/sixteen_bit_vm_execute_unit.sv
// top level of the execute unit: front queue and back executor
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o  | op, reg_a, reg_b, immediate, ...
//  out     | output    | out_valid_o/out_ready_i| program_counter ... divide_by_zero
// most words pass the back part's idle, rd1 and out states; print adds rd2, mov_im
// and mov_rm add wr2, mov_mr adds rd2 and rd3, and div_ir with a nonzero divisor
// adds div (16-step restoring divider). One byte per cycle. a word goes through the
// front queue and these states before the result port. after reset the back part
// clears all 65536 data memory bytes and takes no word then, so the input stalls
// once the two-word front queue is full; input stalls only when the back part lags.
module sixteen_bit_vm_execute_unit import svx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  op_i,
  input  logic [2:0]  reg_a_i,
  input  logic [2:0]  reg_b_i,
  input  logic [15:0] immediate_i,
  input  logic [15:0] target_address_i,
  input  logic        key_present_i,
  input  logic [7:0]  key_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] program_counter_o,
  output logic        halted_o,
  output logic        print_valid_o,
  output logic [7:0]  print_char_o,
  output logic        flag_greater_o,
  output logic        flag_less_o,
  output logic        flag_equal_o,
  output logic        flag_zero_o,
  output logic        divide_by_zero_o
);
  logic   q_valid, q_ready;
  instr_t q_data;

  svx_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .reg_a_i, .reg_b_i,
    .immediate_i, .target_address_i, .key_present_i, .key_byte_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  svx_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o, .out_ready_i, .program_counter_o, .halted_o, .print_valid_o,
    .print_char_o, .flag_greater_o, .flag_less_o, .flag_equal_o, .flag_zero_o,
    .divide_by_zero_o
  );
endmodule

FILE: sim/sixteen_bit_vm_execute_unit_checker.sv
// checker for the execute unit: tracks machine state and compares every result word
`timescale 1ns / 100ps
module sixteen_bit_vm_execute_unit_checker import svx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [4:0]  op_i,
  input  logic [2:0]  reg_a_i,
  input  logic [2:0]  reg_b_i,
  input  logic [15:0] immediate_i,
  input  logic [15:0] target_address_i,
  input  logic        key_present_i,
  input  logic [7:0]  key_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] program_counter_i,
  input  logic        halted_i,
  input  logic        print_valid_i,
  input  logic [7:0]  print_char_i,
  input  logic        flag_greater_i,
  input  logic        flag_less_i,
  input  logic        flag_equal_i,
  input  logic        flag_zero_i,
  input  logic        divide_by_zero_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);

  typedef struct packed {
    logic [15:0] pc;
    logic        halt;
    logic        pv;
    logic [7:0]  pch;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        zf;
    logic        dz;
  } vm_result_t;

  // shadow machine state
  logic [15:0] regs_q [NumRegs];
  logic [15:0] pc_q;
  logic        halt_q, gt_q, lt_q, eq_q, zf_q;
  logic [7:0]  mem_q [MemBytes];
  vm_result_t  expected_q [$];
  int          errors, results;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();
  assign results_o = results;

  // execute one instruction on the shadow state
  function automatic vm_result_t execute_instr(logic [4:0] op, logic [2:0] ra, logic [2:0] rb,
                                               logic [15:0] imm, logic [15:0] tgt,
                                               logic key, logic [7:0] kb);
    vm_result_t r;
    logic [15:0] av, bv;
    logic        jump;
    logic [2:0]  adv;
    r = '0;
    jump = 1'b0;
    adv = 3'd1;
    if (!halt_q) begin
      av = regs_q[ra];
      bv = regs_q[rb];
      case (op_e'(op))
        OP_HLT: begin halt_q = 1'b1; adv = 3'd0; end
        OP_MOV_IR: begin regs_q[ra] = imm; adv = 3'd4; end
        OP_PRINT: begin r.pv = 1'b1; r.pch = mem_q[regs_q[0]]; end
        OP_INC: begin regs_q[ra] = av + 16'd1; adv = 3'd2; end
        OP_DEC: begin regs_q[ra] = av - 16'd1; adv = 3'd2; end
        OP_JMP: jump = 1'b1;
        OP_CMP_I: begin
          gt_q = regs_q[0] > imm;
          lt_q = regs_q[0] < imm;
          eq_q = regs_q[0] == imm;
          zf_q = regs_q[0] == 16'd0;
          adv = 3'd3;
        end
        OP_JE: begin jump = eq_q; adv = 3'd3; end
        OP_JNE: begin jump = !eq_q; adv = 3'd3; end
        OP_JL: begin jump = lt_q; adv = 3'd3; end
        OP_JG: begin jump = gt_q; adv = 3'd3; end
        OP_JLE: begin jump = lt_q || eq_q; adv = 3'd3; end
        OP_JGE: begin jump = gt_q || eq_q; adv = 3'd3; end
        OP_JZ: begin jump = zf_q; adv = 3'd3; end
        OP_JNZ: begin jump = !zf_q; adv = 3'd3; end
        OP_ADD_IR: begin regs_q[0] = av + imm; adv = 3'd4; end
        OP_SUB_IR: begin regs_q[0] = av - imm; adv = 3'd4; end
        OP_MUL_IR: begin regs_q[0] = av * imm; adv = 3'd4; end
        OP_DIV_IR: begin
          if (imm == 16'd0) begin
            regs_q[0] = 16'hFFFF;
            r.dz = 1'b1;
          end else begin
            regs_q[0] = av / imm;
          end
          adv = 3'd4;
        end
        OP_MOV_RR: begin regs_q[ra] = bv; adv = 3'd3; end
        OP_MOV_MR: begin regs_q[ra] = {mem_q[tgt], mem_q[16'(tgt + 16'd1)]}; adv = 3'd4; end
        OP_MOV_IM: begin
          mem_q[tgt] = imm[15:8];
          mem_q[16'(tgt + 16'd1)] = imm[7:0];
          adv = 3'd5;
        end
        OP_MOV_RM: begin
          mem_q[tgt] = av[15:8];
          mem_q[16'(tgt + 16'd1)] = av[7:0];
          adv = 3'd4;
        end
        OP_STDIN: begin
          if (key) begin
            regs_q[ra] = {8'd0, kb};
            zf_q = 1'b0;
          end else begin
            zf_q = 1'b1;
          end
          adv = 3'd2;
        end
        OP_ADD_RR: begin regs_q[ra] = av + bv; adv = 3'd3; end
        default: adv = 3'd1;
      endcase
      pc_q = jump ? tgt : pc_q + 16'(adv);
    end
    r.pc = pc_q;
    r.halt = halt_q;
    r.gt = gt_q;
    r.lt = lt_q;
    r.eq = eq_q;
    r.zf = zf_q;
    return r;
  endfunction

  // observe both channels
  always @(posedge clk_i or negedge rst_ni) begin
    vm_result_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] = '0;
      for (int i = 0; i < MemBytes; i++) mem_q[i] = '0;
      pc_q = '0;
      {halt_q, gt_q, lt_q, eq_q, zf_q} = '0;
      expected_q.delete();
      errors = 0;
      results = 0;
    end else begin
      if (in_valid_i && in_ready_i)
        expected_q.push_back(execute_instr(op_i, reg_a_i, reg_b_i, immediate_i,
                                           target_address_i, key_present_i, key_byte_i));
      if (out_valid_i && out_ready_i) begin
        got = '{program_counter_i, halted_i, print_valid_i, print_char_i, flag_greater_i,
                flag_less_i, flag_equal_i, flag_zero_i, divide_by_zero_i};
        results++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word %h", $time, got);
        end else begin
          want = expected_q.pop_front();
          if (got.pc !== want.pc) begin
            errors++;
            $display("%0t: pc expected %h actual %h", $time, want.pc, got.pc);
          end
          if (got.halt !== want.halt) begin
            errors++;
            $display("%0t: halted expected %b actual %b", $time, want.halt, got.halt);
          end
          if (got.pv !== want.pv) begin
            errors++;
            $display("%0t: print_valid expected %b actual %b", $time, want.pv, got.pv);
          end
          if (got.pch !== want.pch) begin
            errors++;
            $display("%0t: print_char expected %h actual %h", $time, want.pch, got.pch);
          end
          if ({got.gt, got.lt, got.eq, got.zf} !== {want.gt, want.lt, want.eq, want.zf}) begin
            errors++;
            $display("%0t: flags gt/lt/eq/z expected %b actual %b", $time,
                     {want.gt, want.lt, want.eq, want.zf}, {got.gt, got.lt, got.eq, got.zf});
          end
          if (got.dz !== want.dz) begin
            errors++;
            $display("%0t: divide_by_zero expected %b actual %b", $time, want.dz, got.dz);
          end
        end
      end
    end
  end

endmodule

FILE: sim/sixteen_bit_vm_execute_unit_test.sv
// testbench top for the execute unit: clock, reset, instruction stimulus and verdict
`timescale 1ns / 100ps
module sixteen_bit_vm_execute_unit_test import svx_pkg::*;;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [4:0]  op_i;
  logic [2:0]  reg_a_i, reg_b_i;
  logic [15:0] immediate_i, target_address_i;
  logic        key_present_i;
  logic [7:0]  key_byte_i;
  logic [15:0] program_counter_o;
  logic        halted_o, print_valid_o, flag_greater_o, flag_less_o;
  logic        flag_equal_o, flag_zero_o, divide_by_zero_o;
  logic [7:0]  print_char_o;
  int          errors, pending, results;
  int          words_sent;
  bit          long_stall;

  sixteen_bit_vm_execute_unit dut (.*);

  sixteen_bit_vm_execute_unit_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .op_i, .reg_a_i, .reg_b_i,
    .immediate_i, .target_address_i, .key_present_i, .key_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i, .program_counter_i(program_counter_o),
    .halted_i(halted_o), .print_valid_i(print_valid_o), .print_char_i(print_char_o),
    .flag_greater_i(flag_greater_o), .flag_less_i(flag_less_o),
    .flag_equal_i(flag_equal_o), .flag_zero_i(flag_zero_o),
    .divide_by_zero_i(divide_by_zero_o), .errors_o(errors), .pending_o(pending),
    .results_o(results)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // offer one word and hold it until taken; valid drops only before an idle gap
  task automatic send_word(op_e op, logic [2:0] ra, logic [2:0] rb, logic [15:0] imm,
                           logic [15:0] tgt, logic key, logic [7:0] kb);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    reg_a_i          <= ra;
    reg_b_i          <= rb;
    immediate_i      <= imm;
    target_address_i <= tgt;
    key_present_i    <= key;
    key_byte_i       <= kb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  // random word; mostly useful ops, data addresses often near a small window
  task automatic send_random();
    logic [4:0]  op;
    logic [15:0] imm, tgt;
    op = 5'($urandom_range(0, 31));
    // replace halts with compares so the whole random run does real work
    if (op == OP_HLT) op = OP_CMP_I;
    imm = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 8)) : 16'($urandom);
    tgt = $urandom_range(0, 1) == 0 ? 16'($urandom_range(0, 15)) : 16'($urandom);
    if ($urandom_range(0, 15) == 0) tgt = 16'hFFFF;
    send_word(op_e'(op), 3'($urandom), 3'($urandom), imm, tgt, 1'($urandom), 8'($urandom));
  endtask

  // receiver: random wait per word, plus one long hold-off on request
  initial begin
    int wait_n;
    out_ready_i = 1'b0;
    forever begin
      wait_n = $urandom_range(0, 6);
      if (wait_n > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      if (long_stall) begin
        out_ready_i <= 1'b0;
        repeat (60) @(posedge clk_i);
        long_stall = 1'b0;
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // stimulus
  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    op_i             = '0;
    reg_a_i          = '0;
    reg_b_i          = '0;
    immediate_i      = '0;
    target_address_i = '0;
    key_present_i    = 1'b0;
    key_byte_i       = '0;
    words_sent       = 0;
    long_stall       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, wraps, all conditional jumps, divide by zero, stdin both ways
    send_word(OP_PRINT, 0, 0, 0, 0, 0, 0);
    send_word(OP_MOV_IR, 0, 0, 16'hFFFF, 0, 0, 0);
    send_word(OP_INC, 0, 0, 0, 0, 0, 0);
    send_word(OP_DEC, 7, 0, 0, 0, 0, 0);
    send_word(OP_MOV_IM, 0, 0, 16'hA55A, 16'hFFFF, 0, 0);
    send_word(OP_MOV_MR, 3, 0, 0, 16'hFFFF, 0, 0);
    send_word(OP_MOV_RR, 0, 3, 0, 0, 0, 0);
    send_word(OP_ADD_RR, 0, 7, 0, 0, 0, 0);
    send_word(OP_CMP_I, 0, 0, 16'h8000, 0, 0, 0);
    for (int j = OP_JE; j <= OP_JNZ; j++) send_word(op_e'(j), 0, 0, 0, 16'hFFFE, 0, 0);
    send_word(OP_DIV_IR, 0, 0, 0, 0, 0, 0);
    send_word(OP_MUL_IR, 0, 0, 16'hFFFF, 0, 0, 0);
    send_word(OP_SUB_IR, 0, 0, 16'hFFFF, 0, 0, 0);
    send_word(OP_STDIN, 5, 0, 0, 0, 1, 8'hFF);
    send_word(OP_STDIN, 5, 0, 0, 0, 0, 0);
    send_word(OP_MOV_RM, 5, 0, 0, 16'h0000, 0, 0);
    send_word(op_e'(5'd31), 0, 0, 0, 0, 0, 0);
    send_word(OP_IOCFG, 0, 0, 0, 0, 0, 0);

    // random, with a long receiver hold-off early on
    for (int i = 0; i < 780; i++) begin
      if (i == 100) long_stall = 1'b1;
      if (i == 400) begin
        // sender pause until the pipeline drains
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      send_random();
    end
    send_word(OP_HLT, 0, 0, 0, 0, 0, 0);
    send_word(OP_INC, 0, 0, 0, 0, 0, 0);
    send_word(OP_PRINT, 0, 0, 0, 0, 0, 0);
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("run covered %0d instruction words and %0d results, halt at the end",
             words_sent, results);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // timeout: memory clear plus slow worst case, taken several times over
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sixteen_bit_vm_execute_unit.f
rtl/svx_pkg.sv
rtl/svx_ram.sv
rtl/svx_front.sv
rtl/svx_back.sv
rtl/sixteen_bit_vm_execute_unit.sv
sim/sixteen_bit_vm_execute_unit_checker.sv
sim/sixteen_bit_vm_execute_unit_test.sv
